// ===== hw/rtl/acbf_pkg.sv =====
// Shared types and constants of the adaptive cubic Bezier flattener.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package acbf_pkg;

   // Register map of the configuration port
   localparam int TOL_W      = 62;
   localparam int DLIM_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 62;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAT_TOLERANCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_LIMIT    = 1'b1;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 62'd65536;
   localparam logic [DLIM_W-1:0] DLIM_RESET = 3'd5;

   // Coordinates per curve node: four control points, x/y interleaved
   localparam int NUM_COORDS = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NODE,
      ST_SQUARE,
      ST_SPLIT,
      ST_EMIT,
      ST_POP
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/acbf_stack.sv =====
// Subdivision stack memory of the flattener: one row per pending right half.
// Synchronous write, registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module acbf_stack #(
   parameter int ROW_W = 339,
   parameter int DEPTH = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [ROW_W-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [ROW_W-1:0]         rd_data
);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/acbf_err.sv =====
// Flatness error unit: forms the four deviation terms of a node, then squares
// them one at a time on a shared multiplier. Uses acbf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acbf_err #(
   parameter int WW = 42,
   parameter int LW = 3,
   parameter int CB = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [WW-1:0] work [acbf_pkg::NUM_COORDS],
   input  wire logic        [LW-1:0] level,
   output logic                      done,
   output logic [2*(CB+2):0]         err
);

   localparam int TW = WW + 3;       // signed term width
   localparam int MW = CB + 2;       // truncated magnitude width
   localparam int PW = 2 * MW;       // square width
   localparam int EW = PW + 1;       // error sum width
   localparam int SHW = LW + 2;

   logic [MW-1:0]  mag_ff [4];
   logic [MW-1:0]  mag    [4];
   logic [PW-1:0]  prod_ff;
   logic [PW-1:0]  mx_ff;
   logic [PW-1:0]  acc_ff;
   logic [EW-1:0]  err_ff;
   logic [2:0]     cnt_ff;
   logic           run_ff;
   logic           done_ff;
   logic [PW-1:0]  big;

   logic signed [TW-1:0] term [4];
   logic signed [TW-1:0] we [acbf_pkg::NUM_COORDS];
   logic [TW-1:0]        absv [4];
   logic [TW-1:0]        shv  [4];
   logic [SHW-1:0]       sh;

   // Terms in order ax, bx, ay, by
   always_comb begin
      for (int i = 0; i < acbf_pkg::NUM_COORDS; i++) begin
         we[i] = TW'(work[i]);
      end
      sh = SHW'({level, 1'b0}) + SHW'(level);
      term[0] = (we[2] <<< 1) + we[2] - (we[0] <<< 1) - we[6];
      term[1] = (we[4] <<< 1) + we[4] - we[0] - (we[6] <<< 1);
      term[2] = (we[3] <<< 1) + we[3] - (we[1] <<< 1) - we[7];
      term[3] = (we[5] <<< 1) + we[5] - we[1] - (we[7] <<< 1);
      for (int k = 0; k < 4; k++) begin
         absv[k] = term[k][TW-1] ? TW'(-term[k]) : TW'(term[k]);
         shv[k]  = absv[k] >> sh;
         mag[k]  = shv[k][MW-1:0];
      end
   end

   assign big = (mx_ff > prod_ff) ? mx_ff : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == 3'd4);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // Issue one square per cycle, fold the previous one into max/sum
   always_ff @(posedge clock) begin
      if (start) begin
         for (int k = 0; k < 4; k++) begin
            mag_ff[k] <= mag[k];
         end
      end
      if (run_ff) begin
         if (cnt_ff < 3'd4) begin
            prod_ff <= PW'(mag_ff[cnt_ff[1:0]]) * PW'(mag_ff[cnt_ff[1:0]]);
         end
         case (cnt_ff)
            3'd1: mx_ff <= prod_ff;
            3'd2: mx_ff <= big;
            3'd3: begin
               acc_ff <= mx_ff;
               mx_ff  <= prod_ff;
            end
            3'd4: err_ff <= EW'(acc_ff) + EW'(big);
            default: ;
         endcase
      end
   end

   assign done = done_ff;
   assign err  = err_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/adaptive_cubic_bezier_flattener.sv =====
// Top level of the adaptive cubic Bezier flattener: control sequencer,
// de Casteljau split datapath and output register. Uses acbf_pkg, acbf_stack
// and acbf_err.
//
// Usage:
//  - req_* carries one curve (four control points, signed Q16.8). The block
//    takes a curve only when idle and then walks the subdivision tree depth
//    first, keeping the pending right halves in a stack memory.
//  - rsp_* returns the polyline vertices in curve order; rsp_last_point marks
//    the final vertex of the curve. Every curve gives between 1 and
//    2^(MAX_DEPTH+1) vertices.
//  - Sequence: a tested node goes from setup through the shared squaring
//    unit; a node past the level limit, or met with a full stack, skips the
//    test. A split, an emit and a pop from the stack (the registered memory
//    read) each pass through a state of their own. The block takes no new
//    curve until it is back in idle after the last vertex of the current one.
//  - csr_* writes flat_tolerance (index 0) and depth_limit (index 1);
//    write only while no curve is in flight.
//  - Reset clears the sequencer and the output valid and restores the
//    register reset values; the stack memory needs no clearing.
//  - A stalled receiver holds the vertex in the output register and the walk
//    waits at the next vertex until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_cubic_bezier_flattener #(
   parameter int MAX_DEPTH  = 5,
   parameter int COORD_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [COORD_BITS-1:0]          req_start_x,
   input  wire logic signed [COORD_BITS-1:0]          req_start_y,
   input  wire logic signed [COORD_BITS-1:0]          req_ctrl_a_x,
   input  wire logic signed [COORD_BITS-1:0]          req_ctrl_a_y,
   input  wire logic signed [COORD_BITS-1:0]          req_ctrl_b_x,
   input  wire logic signed [COORD_BITS-1:0]          req_ctrl_b_y,
   input  wire logic signed [COORD_BITS-1:0]          req_end_x,
   input  wire logic signed [COORD_BITS-1:0]          req_end_y,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [COORD_BITS-1:0]               rsp_point_x,
   output logic signed [COORD_BITS-1:0]               rsp_point_y,
   output logic                                       rsp_last_point,
   input  wire logic                                  csr_we,
   input  wire logic [acbf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [acbf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int LVL_MAX   = MAX_DEPTH + 1;
   localparam int LW        = $clog2(LVL_MAX + 1);
   localparam int STK_DEPTH = MAX_DEPTH + 1;
   localparam int STK_AW    = $clog2(STK_DEPTH);
   localparam int SPW       = $clog2(STK_DEPTH + 1);
   localparam int WW        = COORD_BITS + 3 * LVL_MAX;
   localparam int NC        = acbf_pkg::NUM_COORDS;
   localparam int ROW_W     = NC * WW + LW;
   localparam int EW        = 2 * (COORD_BITS + 2) + 1;
   localparam int CMP_W     = (EW > acbf_pkg::TOL_W) ? EW : acbf_pkg::TOL_W;
   localparam int SHW       = LW + 2;

   acbf_pkg::state_type state_ff, state_in;

   logic signed [WW-1:0]           work_ff [NC];
   logic [LW-1:0]                  level_ff;
   logic [SPW-1:0]                 sp_ff;
   logic [acbf_pkg::TOL_W-1:0]     tol_ff;
   logic [acbf_pkg::DLIM_W-1:0]    dlim_ff;
   logic                           rsp_valid_ff;
   logic signed [COORD_BITS-1:0]   rsp_x_ff, rsp_y_ff;
   logic                           rsp_last_ff;

   logic                 load_item, err_start, push, pop_rd, emit_fire;
   logic                 force_emit, slot_free, is_flat;
   logic [31:0]          lim_val;
   logic                 err_done;
   logic [EW-1:0]        err_val;
   logic [ROW_W-1:0]     push_row, pop_row;
   logic signed [WW-1:0] left [NC];
   logic signed [WW-1:0] right [NC];
   logic signed [WW-1:0] p [NC];
   logic signed [WW-1:0] m12 [2], m23 [2], m34 [2], m123 [2], m234 [2], m1234 [2];
   logic [SHW-1:0]       sh;
   logic signed [WW-1:0] out_x, out_y;

   function automatic logic signed [WW-1:0] mid(input logic signed [WW-1:0] a,
                                                input logic signed [WW-1:0] b);
      logic signed [WW:0] s;
      s = (WW+1)'(a) + (WW+1)'(b);
      return WW'(s >>> 1);
   endfunction

   // Level limit saturates at MAX_DEPTH; a full stack also forces a vertex
   assign lim_val = (32'(dlim_ff) > 32'(MAX_DEPTH)) ? 32'(MAX_DEPTH) : 32'(dlim_ff);
   assign force_emit = (32'(level_ff) > lim_val) || (32'(sp_ff) >= 32'(STK_DEPTH));
   assign is_flat = CMP_W'(err_val) <= CMP_W'(tol_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Split at t = 1/2 after scaling by 8; every midpoint is exact
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         p[i] = work_ff[i] <<< 3;
      end
      for (int c = 0; c < 2; c++) begin
         m12[c]   = mid(p[c], p[2+c]);
         m23[c]   = mid(p[2+c], p[4+c]);
         m34[c]   = mid(p[4+c], p[6+c]);
         m123[c]  = mid(m12[c], m23[c]);
         m234[c]  = mid(m23[c], m34[c]);
         m1234[c] = mid(m123[c], m234[c]);
      end
      left[0] = p[0];      left[1] = p[1];
      left[2] = m12[0];    left[3] = m12[1];
      left[4] = m123[0];   left[5] = m123[1];
      left[6] = m1234[0];  left[7] = m1234[1];
      right[0] = m1234[0]; right[1] = m1234[1];
      right[2] = m234[0];  right[3] = m234[1];
      right[4] = m34[0];   right[5] = m34[1];
      right[6] = p[6];     right[7] = p[7];
      push_row = '0;
      for (int i = 0; i < NC; i++) begin
         push_row[i*WW +: WW] = right[i];
      end
      push_row[NC*WW +: LW] = level_ff + LW'(1);
   end

   // Vertex: floor to 8 fraction bits
   assign sh    = SHW'({level_ff, 1'b0}) + SHW'(level_ff);
   assign out_x = work_ff[6] >>> sh;
   assign out_y = work_ff[7] >>> sh;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acbf_pkg::ST_IDLE: begin
            if (req_valid) state_in = acbf_pkg::ST_NODE;
         end
         acbf_pkg::ST_NODE: begin
            state_in = force_emit ? acbf_pkg::ST_EMIT : acbf_pkg::ST_SQUARE;
         end
         acbf_pkg::ST_SQUARE: begin
            if (err_done) state_in = is_flat ? acbf_pkg::ST_EMIT : acbf_pkg::ST_SPLIT;
         end
         acbf_pkg::ST_SPLIT: state_in = acbf_pkg::ST_NODE;
         acbf_pkg::ST_EMIT: begin
            if (slot_free) state_in = (sp_ff == '0) ? acbf_pkg::ST_IDLE : acbf_pkg::ST_POP;
         end
         acbf_pkg::ST_POP: state_in = acbf_pkg::ST_NODE;
         default: state_in = acbf_pkg::ST_IDLE;
      endcase
   end

   // Control decode
   always_comb begin
      req_ready = 1'b0;
      load_item = 1'b0;
      err_start = 1'b0;
      push      = 1'b0;
      pop_rd    = 1'b0;
      emit_fire = 1'b0;
      case (state_ff)
         acbf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            load_item = req_valid;
         end
         acbf_pkg::ST_NODE:  err_start = !force_emit;
         acbf_pkg::ST_SPLIT: push = 1'b1;
         acbf_pkg::ST_EMIT: begin
            emit_fire = slot_free;
            pop_rd    = slot_free && (sp_ff != '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acbf_pkg::ST_IDLE;
         sp_ff        <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= acbf_pkg::TOL_RESET;
         dlim_ff      <= acbf_pkg::DLIM_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               acbf_pkg::CSR_FLAT_TOLERANCE: tol_ff <= csr_wdata[acbf_pkg::TOL_W-1:0];
               acbf_pkg::CSR_DEPTH_LIMIT:    dlim_ff <= csr_wdata[acbf_pkg::DLIM_W-1:0];
               default: ;
            endcase
         end
         if (load_item) begin
            sp_ff    <= '0;
            level_ff <= '0;
         end else if (push) begin
            sp_ff    <= sp_ff + SPW'(1);
            level_ff <= level_ff + LW'(1);
         end else if (pop_rd) begin
            sp_ff <= sp_ff - SPW'(1);
         end else if (state_ff == acbf_pkg::ST_POP) begin
            level_ff <= pop_row[NC*WW +: LW];
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working node and output payload
   always_ff @(posedge clock) begin
      if (load_item) begin
         work_ff[0] <= WW'(req_start_x);
         work_ff[1] <= WW'(req_start_y);
         work_ff[2] <= WW'(req_ctrl_a_x);
         work_ff[3] <= WW'(req_ctrl_a_y);
         work_ff[4] <= WW'(req_ctrl_b_x);
         work_ff[5] <= WW'(req_ctrl_b_y);
         work_ff[6] <= WW'(req_end_x);
         work_ff[7] <= WW'(req_end_y);
      end else if (push) begin
         for (int i = 0; i < NC; i++) begin
            work_ff[i] <= left[i];
         end
      end else if (state_ff == acbf_pkg::ST_POP) begin
         for (int i = 0; i < NC; i++) begin
            work_ff[i] <= pop_row[i*WW +: WW];
         end
      end
      if (emit_fire) begin
         rsp_x_ff    <= out_x[COORD_BITS-1:0];
         rsp_y_ff    <= out_y[COORD_BITS-1:0];
         rsp_last_ff <= (sp_ff == '0);
      end
   end

   acbf_stack #(
      .ROW_W (ROW_W),
      .DEPTH (STK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (sp_ff[STK_AW-1:0]),
      .wr_data (push_row),
      .rd_en   (pop_rd),
      .rd_addr (STK_AW'(sp_ff - SPW'(1))),
      .rd_data (pop_row)
   );

   acbf_err #(
      .WW (WW),
      .LW (LW),
      .CB (COORD_BITS)
   ) u_err (
      .clock (clock),
      .reset (reset),
      .start (err_start),
      .work  (work_ff),
      .level (level_ff),
      .done  (err_done),
      .err   (err_val)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_last_point = rsp_last_ff;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for adaptive_cubic_bezier_flattener: random and directed
// curves under several tolerance and depth settings, with a built-in vertex predictor.
// Depends on acbf_pkg and the flattener RTL.
`timescale 1ns / 1ps
module tb;

   localparam int CB        = 24;
   localparam int MAX_LVL   = 5;
   localparam int STK_DEPTH = MAX_LVL + 1;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct {
      coord_type c[8];   // x1 y1 x2 y2 x3 y3 x4 y4
   } curve_type;
   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            req_valid = 1'b0;
   logic            req_ready;
   coord_type       req_start_x = '0, req_start_y = '0, req_ctrl_a_x = '0, req_ctrl_a_y = '0;
   coord_type       req_ctrl_b_x = '0, req_ctrl_b_y = '0, req_end_x = '0, req_end_y = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   coord_type       rsp_point_x, rsp_point_y;
   logic            rsp_last_point;
   logic                            csr_we = 1'b0;
   logic [acbf_pkg::CSR_IDX_W-1:0]  csr_index = acbf_pkg::CSR_FLAT_TOLERANCE;
   logic [acbf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Mirror of the block's registers, updated as each write lands
   logic [acbf_pkg::TOL_W-1:0]  tol_cfg  = acbf_pkg::TOL_RESET;
   logic [acbf_pkg::DLIM_W-1:0] dlim_cfg = acbf_pkg::DLIM_RESET;

   curve_type  curves_to_send[$];
   vertex_type expected_vertices[$];
   int      mismatches    = 0;
   int      curves_sent   = 0;
   int      vertices_seen = 0;
   int      most_vertices = 0;
   bit      drain_mode    = 0;   // sender holds off until all vertices are back
   bit      no_idle       = 0;   // suppress gaps and stalls on both sides

   adaptive_cubic_bezier_flattener u_dut (
      .clock, .reset,
      .req_valid, .req_ready,
      .req_start_x, .req_start_y, .req_ctrl_a_x, .req_ctrl_a_y,
      .req_ctrl_b_x, .req_ctrl_b_y, .req_end_x, .req_end_y,
      .rsp_valid, .rsp_ready, .rsp_point_x, .rsp_point_y, .rsp_last_point,
      .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint unsigned sq_trunc(longint v, int s);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = m >> s;
      return m * m;
   endfunction

   // Walk the subdivision tree depth first and queue up the vertices it emits
   function automatic void flatten_curve(curve_type cv);
      longint          w[8], p[8];
      longint          stk[STK_DEPTH][8];
      int              stk_lvl[STK_DEPTH];
      int              depth, lvl, lim, n, s, k;
      longint          ax, ay, bx, by;
      longint          m12[2], m23[2], m34[2], m123[2], m234[2], m1234[2];
      longint unsigned ex, fx, ey, fy, err;
      bit              emit, done;
      vertex_type      vx;
      lim   = (dlim_cfg > MAX_LVL) ? MAX_LVL : int'(dlim_cfg);
      for (k = 0; k < 8; k++) w[k] = longint'(cv.c[k]);
      lvl   = 0;
      depth = 0;
      n     = 0;
      done  = 0;
      while (!done) begin
         s    = 3 * lvl;
         emit = (lvl > lim) || (depth >= STK_DEPTH);
         if (!emit) begin
            ax  = 3 * w[2] - 2 * w[0] - w[6];
            ay  = 3 * w[3] - 2 * w[1] - w[7];
            bx  = 3 * w[4] - w[0] - 2 * w[6];
            by  = 3 * w[5] - w[1] - 2 * w[7];
            ex  = sq_trunc(ax, s);
            fx  = sq_trunc(bx, s);
            ey  = sq_trunc(ay, s);
            fy  = sq_trunc(by, s);
            err = ((ex > fx) ? ex : fx) + ((ey > fy) ? ey : fy);
            emit = err <= longint'(tol_cfg);
         end
         if (emit) begin
            // arithmetic shift floors toward minus infinity
            vx.x    = coord_type'(w[6] >>> s);
            vx.y    = coord_type'(w[7] >>> s);
            vx.last = 1'b0;
            expected_vertices.insert(expected_vertices.size(), vx);
            n++;
            if (depth == 0) done = 1;
            else begin
               depth--;
               for (k = 0; k < 8; k++) w[k] = stk[depth][k];
               lvl = stk_lvl[depth];
            end
         end else begin
            for (k = 0; k < 8; k++) p[k] = w[k] * 8;
            for (k = 0; k < 2; k++) begin
               m12[k]   = (p[k] + p[2 + k]) / 2;
               m23[k]   = (p[2 + k] + p[4 + k]) / 2;
               m34[k]   = (p[4 + k] + p[6 + k]) / 2;
               m123[k]  = (m12[k] + m23[k]) / 2;
               m234[k]  = (m23[k] + m34[k]) / 2;
               m1234[k] = (m123[k] + m234[k]) / 2;
               stk[depth][k]     = m1234[k];
               stk[depth][2 + k] = m234[k];
               stk[depth][4 + k] = m34[k];
               stk[depth][6 + k] = p[6 + k];
               w[k]     = p[k];
               w[2 + k] = m12[k];
               w[4 + k] = m123[k];
               w[6 + k] = m1234[k];
            end
            stk_lvl[depth] = lvl + 1;
            depth++;
            lvl++;
         end
      end
      expected_vertices[expected_vertices.size() - 1].last = 1'b1;
      if (n > most_vertices) most_vertices = n;
   endfunction

   // Sender: predict on acceptance, then present the next curve or idle
   int send_gap = 0;
   always @(posedge clock) begin
      curve_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            flatten_curve('{c: '{req_start_x, req_start_y, req_ctrl_a_x, req_ctrl_a_y,
                                 req_ctrl_b_x, req_ctrl_b_y, req_end_x, req_end_y}});
            curves_sent++;
         end
         if (req_valid && !req_ready) begin
            // hold the item until it is taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (curves_to_send.size() > 0 &&
                      !(drain_mode && expected_vertices.size() > 0)) begin
            nxt = curves_to_send.pop_front();
            req_start_x  <= nxt.c[0];
            req_start_y  <= nxt.c[1];
            req_ctrl_a_x <= nxt.c[2];
            req_ctrl_a_y <= nxt.c[3];
            req_ctrl_b_x <= nxt.c[4];
            req_ctrl_b_y <= nxt.c[5];
            req_end_x    <= nxt.c[6];
            req_end_y    <= nxt.c[7];
            req_valid    <= 1'b1;
            send_gap     = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: compare each vertex with the oldest prediction, stall at random
   int recv_stall = 0;
   always @(posedge clock) begin
      vertex_type exp_v;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            vertices_seen++;
            if (expected_vertices.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected vertex x=%0d y=%0d last=%0b", $time,
                        rsp_point_x, rsp_point_y, rsp_last_point);
            end else begin
               exp_v = expected_vertices.pop_front();
               if (rsp_point_x !== exp_v.x) begin
                  mismatches++;
                  $display("%0t: point_x expected %0d actual %0d", $time, exp_v.x, rsp_point_x);
               end
               if (rsp_point_y !== exp_v.y) begin
                  mismatches++;
                  $display("%0t: point_y expected %0d actual %0d", $time, exp_v.y, rsp_point_y);
               end
               if (rsp_last_point !== exp_v.last) begin
                  mismatches++;
                  $display("%0t: last_point expected %0b actual %0b", $time,
                           exp_v.last, rsp_last_point);
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            recv_stall = idle_len();
         end
      end
   end

   task automatic write_csr(logic [acbf_pkg::CSR_IDX_W-1:0] idx,
                            logic [acbf_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == acbf_pkg::CSR_FLAT_TOLERANCE) tol_cfg = val[acbf_pkg::TOL_W-1:0];
      else dlim_cfg = val[acbf_pkg::DLIM_W-1:0];
   endtask

   // Wait for the block to go idle, then let the clock run on before the next phase
   task automatic drain();
      while (curves_to_send.size() > 0 || req_valid || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic void add_curve(curve_type cv);
      curves_to_send.insert(curves_to_send.size(), cv);
   endfunction

   function automatic coord_type near(longint center, longint span);
      longint v;
      v = center + longint'($urandom_range(0, 2 * span)) - span;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return coord_type'(v);
   endfunction

   // Mostly local curves of varied size so the tree goes to every depth
   task automatic queue_random(int count);
      curve_type cv;
      longint cx, cy, span;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int k = 0; k < 8; k++) cv.c[k] = coord_type'($urandom);
         end else begin
            cx   = longint'($signed(coord_type'($urandom)));
            cy   = longint'($signed(coord_type'($urandom)));
            span = longint'(1) << $urandom_range(2, 21);
            for (int k = 0; k < 8; k += 2) begin
               cv.c[k]     = near(cx, span);
               cv.c[k + 1] = near(cy, span);
            end
         end
         add_curve(cv);
      end
   endtask

   task automatic queue_directed();
      coord_type mx, mn;
      mx = 24'sh7FFFFF;
      mn = -24'sh800000;
      add_curve('{c: '{mx, mx, mx, mx, mx, mx, mx, mx}});
      add_curve('{c: '{mn, mn, mn, mn, mn, mn, mn, mn}});
      // degenerate curves: every point in one place
      add_curve('{c: '{0, 0, 0, 0, 0, 0, 0, 0}});
      add_curve('{c: '{-1, -1, -1, -1, -1, -1, -1, -1}});
      add_curve('{c: '{mn, mn, mx, mx, mn, mn, mx, mx}});
      add_curve('{c: '{mn, mx, mx, mn, mn, mx, mx, mn}});
      add_curve('{c: '{mx, mn, mn, mx, mx, mn, mn, mx}});
      // straight line with evenly spaced controls
      add_curve('{c: '{0, 0, 256, 256, 512, 512, 768, 768}});
      // cusp / loop shapes and negative end points that exercise the floor
      add_curve('{c: '{0, 0, 4096, 4096, -4096, 4096, 0, 0}});
      add_curve('{c: '{-3, -5, 1000, -7, -1000, 13, -1, -1}});
      add_curve('{c: '{24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555,
                       24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555}});
      add_curve('{c: '{0, 0, 0, 2560, 2560, 2560, 2560, 0}});
   endtask

   initial begin
      logic [acbf_pkg::CSR_DATA_W-1:0] rnd_tol;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default registers
      queue_directed();
      queue_random(40);
      drain();

      // zero tolerance, depth above the maximum: full trees
      write_csr(acbf_pkg::CSR_FLAT_TOLERANCE, '0);
      write_csr(acbf_pkg::CSR_DEPTH_LIMIT, 3'd7);
      queue_directed();
      queue_random(15);
      drain();

      // largest tolerance, depth zero: one vertex per curve
      write_csr(acbf_pkg::CSR_FLAT_TOLERANCE, {acbf_pkg::CSR_DATA_W{1'b1}});
      write_csr(acbf_pkg::CSR_DEPTH_LIMIT, 3'd0);
      queue_random(40);
      drain();

      // depth zero with zero tolerance: at most one split per curve
      write_csr(acbf_pkg::CSR_FLAT_TOLERANCE, '0);
      queue_random(30);
      drain();

      // random settings, one curve at a time
      rnd_tol = {$urandom, $urandom};
      write_csr(acbf_pkg::CSR_FLAT_TOLERANCE, rnd_tol >> $urandom_range(10, 61));
      write_csr(acbf_pkg::CSR_DEPTH_LIMIT, acbf_pkg::DLIM_W'($urandom_range(1, 6)));
      drain_mode = 1;
      queue_random(50);
      drain();
      drain_mode = 0;

      // back to back at a mid tolerance
      write_csr(acbf_pkg::CSR_FLAT_TOLERANCE, 62'd1 << $urandom_range(8, 30));
      write_csr(acbf_pkg::CSR_DEPTH_LIMIT, 3'd3);
      no_idle = 1;
      queue_random(60);
      drain();
      no_idle = 0;

      write_csr(acbf_pkg::CSR_FLAT_TOLERANCE, 62'd1 << 32);
      write_csr(acbf_pkg::CSR_DEPTH_LIMIT, 3'd5);
      queue_random(55);
      drain();

      if (expected_vertices.size() != 0) mismatches++;
      $display("Flattened %0d curves into %0d vertices (up to %0d per curve) over seven",
               curves_sent, vertices_seen, most_vertices);
      $display("tolerance/depth settings, with %0d mismatches.", mismatches);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end
endmodule
